[rtl/core/sbcc_pkg.sv]
// shared package for the segment/box clip collision checker
// queue depth and the queue status bundle; no dependencies
`default_nettype none
package sbcc_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[rtl/core/segment_box_clip_collision_top.sv]
// top level of the segment versus grown box collision checker
// instantiates sbcc_front, sbcc_fifo and sbcc_back; uses sbcc_pkg
`default_nettype none
// Takes one query per cycle unless the queue is full, and returns one hit flag per
// query, in order. A query moves through an input register, a four-entry queue and
// a four-stage back end (partial products, product sums, line-side sums, compare into
// the output register). The back end stalls as a whole while its output waits; the
// queue keeps the front end taking requests during short stalls. Hit means the closed
// segment meets the closed box grown by the agent radius on every side, computed
// exactly.
module segment_box_clip_collision_top #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // start_x, start_y, end_x, end_y, box_center_x, box_center_y,
  // box_width, box_height, grow_radius, zero fill
  input  wire logic [((9*COORD_BITS-3)+7)/8*8-1:0] s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // hit, zero fill
  output logic [7:0]                 m_tdata
);
  import sbcc_pkg::*;

  localparam int IN_BITS   = ((9 * COORD_BITS - 3) + 7) / 8 * 8;
  localparam int ITEM_BITS = 3 + 6 * (COORD_BITS + 1);

  q_stat_t q_stat;
  logic push, pop;
  logic [ITEM_BITS-1:0] f_item, q_item;

  sbcc_front #(.COORD_BITS(COORD_BITS), .IN_BITS(IN_BITS), .ITEM_BITS(ITEM_BITS)) u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .q_stat(q_stat), .push(push), .item(f_item)
  );

  sbcc_fifo #(.WIDTH(ITEM_BITS)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(f_item), .pop(pop), .rdata(q_item),
    .q_stat(q_stat)
  );

  sbcc_back #(.COORD_BITS(COORD_BITS), .ITEM_BITS(ITEM_BITS)) u_back (
    .clk(clk), .rst(rst), .q_stat(q_stat), .item(q_item), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire

[rtl/core/sbcc_front.sv]
// front end: takes a request, doubles coordinates, builds the box edges,
// runs the bounding-box overlap test and the magnitudes for the line test; uses sbcc_pkg
`default_nettype none
module sbcc_front #(
  parameter int COORD_BITS = 32,
  parameter int IN_BITS    = 288,
  parameter int ITEM_BITS  = 3 + 6 * (COORD_BITS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_BITS-1:0]   s_tdata,
  input  wire sbcc_pkg::q_stat_t    q_stat,
  output logic                      push,
  output logic [ITEM_BITS-1:0]      item
);
  import sbcc_pkg::*;

  localparam int C = COORD_BITS;
  localparam int M = C + 1;
  localparam int W = C + 3;

  logic signed [W-1:0] ax2, ay2, bx2, by2, cx2, cy2;
  logic signed [W-1:0] hw, hh;
  logic signed [W-1:0] xlo, xhi, ylo, yhi;
  logic signed [W-1:0] xmin, xmax, ymin, ymax;
  logic signed [W-1:0] dx, dy, ex, ey;
  logic [M-1:0] adx, ady, aex, aey;
  logic boxok, s1, s2;
  logic fr_valid;
  logic [ITEM_BITS-1:0] fr_item;

  always_comb begin
    ax2 = W'($signed(s_tdata[0*C +: C])) <<< 1;
    ay2 = W'($signed(s_tdata[1*C +: C])) <<< 1;
    bx2 = W'($signed(s_tdata[2*C +: C])) <<< 1;
    by2 = W'($signed(s_tdata[3*C +: C])) <<< 1;
    cx2 = W'($signed(s_tdata[4*C +: C])) <<< 1;
    cy2 = W'($signed(s_tdata[5*C +: C])) <<< 1;
    hw  = W'({1'b0, s_tdata[6*C +: C-1]})
        + (W'({1'b0, s_tdata[6*C + 2*(C-1) +: C-1]}) <<< 1);
    hh  = W'({1'b0, s_tdata[6*C + (C-1) +: C-1]})
        + (W'({1'b0, s_tdata[6*C + 2*(C-1) +: C-1]}) <<< 1);
    xlo = cx2 - hw;
    xhi = cx2 + hw;
    ylo = cy2 - hh;
    yhi = cy2 + hh;
    xmin = (ax2 < bx2) ? ax2 : bx2;
    xmax = (ax2 < bx2) ? bx2 : ax2;
    ymin = (ay2 < by2) ? ay2 : by2;
    ymax = (ay2 < by2) ? by2 : ay2;
    boxok = (xmin <= xhi) && (xmax >= xlo) && (ymin <= yhi) && (ymax >= ylo);
    dx = bx2 - ax2;
    dy = by2 - ay2;
    ex = cx2 - ax2;
    ey = cy2 - ay2;
    adx = dx[W-1] ? M'(-dx) : M'(dx);
    ady = dy[W-1] ? M'(-dy) : M'(dy);
    aex = ex[W-1] ? M'(-ex) : M'(ex);
    aey = ey[W-1] ? M'(-ey) : M'(ey);
    s1 = dx[W-1] ^ ey[W-1];
    s2 = dy[W-1] ^ ex[W-1];
  end

  assign push     = fr_valid && !q_stat.full;
  assign s_tready = !fr_valid || !q_stat.full;
  assign item     = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (s_tready) begin
      fr_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      fr_item <= {boxok, s1, s2, adx, ady, aex, aey, M'(hw), M'(hh)};
    end
  end

endmodule
`default_nettype wire

[rtl/core/sbcc_fifo.sv]
// short request queue between front and back end
// register array with read and write pointers; uses sbcc_pkg
`default_nettype none
module sbcc_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output sbcc_pkg::q_stat_t     q_stat
);
  import sbcc_pkg::*;

  logic [WIDTH-1:0] mem [QDEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QCNT_BITS-1:0] count;

  assign rdata        = mem[rptr];
  assign q_stat.full  = (count == QCNT_BITS'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

[rtl/core/sbcc_back.sv]
// back end: split multiplies for the line-side test, sum, compare, output register
// pulls requests from sbcc_fifo; uses sbcc_pkg
`default_nettype none
module sbcc_back #(
  parameter int COORD_BITS = 32,
  parameter int ITEM_BITS  = 3 + 6 * (COORD_BITS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sbcc_pkg::q_stat_t    q_stat,
  input  wire logic [ITEM_BITS-1:0] item,
  output logic                      pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata
);
  import sbcc_pkg::*;

  localparam int M  = COORD_BITS + 1;
  localparam int LO = (M + 1) / 2;
  localparam int HI = M - LO;
  localparam int PW = 2 * M;

  logic boxok_i, s1_i, s2_i;
  logic [M-1:0] adx, ady, aex, aey, ahw, ahh;
  logic adv;

  logic v1, v2, v3;
  logic b1, b2, b3, t1, t2;
  logic [M+LO-1:0] p1l, p2l, g1l, g2l;
  logic [M+HI-1:0] p1h, p2h, g1h, g2h;
  logic [PW-1:0] prod1, prod2, gp1, gp2;
  logic [PW:0] fmag, gsum;
  logic hit;

  assign {boxok_i, s1_i, s2_i, adx, ady, aex, aey, ahw, ahh} = item;
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= !q_stat.empty;
      v2 <= v1;
      v3 <= v2;
      m_tvalid <= v3;
    end
  end

  // partial products, multiplier split into low and high halves
  always_ff @(posedge clk) begin
    if (adv) begin
      b1  <= boxok_i;
      t1  <= (s1_i != s2_i);
      p1l <= (M+LO)'(adx) * (M+LO)'(aey[LO-1:0]);
      p1h <= (M+HI)'(adx) * (M+HI)'(aey[M-1:LO]);
      p2l <= (M+LO)'(ady) * (M+LO)'(aex[LO-1:0]);
      p2h <= (M+HI)'(ady) * (M+HI)'(aex[M-1:LO]);
      g1l <= (M+LO)'(adx) * (M+LO)'(ahh[LO-1:0]);
      g1h <= (M+HI)'(adx) * (M+HI)'(ahh[M-1:LO]);
      g2l <= (M+LO)'(ady) * (M+LO)'(ahw[LO-1:0]);
      g2h <= (M+HI)'(ady) * (M+HI)'(ahw[M-1:LO]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2    <= b1;
      t2    <= t1;
      prod1 <= PW'(p1l) + (PW'(p1h) << LO);
      prod2 <= PW'(p2l) + (PW'(p2h) << LO);
      gp1   <= PW'(g1l) + (PW'(g1h) << LO);
      gp2   <= PW'(g2l) + (PW'(g2h) << LO);
    end
  end

  // line-side distance of the centre against the box spread
  always_ff @(posedge clk) begin
    if (adv) begin
      b3 <= b2;
      if (t2) fmag <= (PW+1)'(prod1) + (PW+1)'(prod2);
      else if (prod1 >= prod2) fmag <= (PW+1)'(prod1 - prod2);
      else fmag <= (PW+1)'(prod2 - prod1);
      gsum <= (PW+1)'(gp1) + (PW+1)'(gp2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= b3 && (fmag <= gsum);
    end
  end

  assign m_tdata = {7'b0, hit};

endmodule
`default_nettype wire
